### sv/spq_pkg.sv
package spq_pkg;

  // Action codes carried on the input channel
  localparam logic [1:0] ACT_ENQUEUE = 2'd0;
  localparam logic [1:0] ACT_DEQUEUE = 2'd1;
  localparam logic [1:0] ACT_DRAIN   = 2'd2;
  localparam logic [1:0] ACT_CLEAR   = 2'd3;

  // Field widths
  localparam int ACTION_W = 2;
  localparam int PRIO_W   = 16;
  localparam int TAG_W    = 16;
  localparam int DRAIN_W  = 5;
  localparam int OCC_W    = 5;

  // Default store depth and per-item result limit
  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int MAX_RESULTS     = 16;

  // Commands from controller to datapath
  typedef struct packed {
    logic ins;         // insert the input entry in sorted place
    logic pop;         // remove the head entry
    logic clr;         // empty the store
    logic load;        // load the output register
    logic item_valid;  // output beat carries the head entry
    logic overflow;    // output beat flags a dropped enqueue
    logic last;        // output beat ends the item
  } spq_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic empty;
    logic single;      // exactly one entry held
    logic full;
  } spq_sts_t;

endpackage

### sv/spq_datapath.sv
module spq_datapath #(
  parameter int QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  spq_pkg::spq_cmd_t          cmd,
  output spq_pkg::spq_sts_t          sts,
  input  logic [spq_pkg::PRIO_W-1:0] in_priority_req,
  input  logic [spq_pkg::TAG_W-1:0]  in_item_tag,
  output logic                       out_item_valid,
  output logic [spq_pkg::PRIO_W-1:0] out_priority,
  output logic [spq_pkg::TAG_W-1:0]  out_tag,
  output logic [spq_pkg::OCC_W-1:0]  out_occupancy,
  output logic                       out_overflow,
  output logic                       out_last
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [spq_pkg::PRIO_W-1:0] prio_r   [QUEUE_DEPTH];
  logic [spq_pkg::PRIO_W-1:0] prio_nxt [QUEUE_DEPTH];
  logic [spq_pkg::TAG_W-1:0]  tag_r    [QUEUE_DEPTH];
  logic [spq_pkg::TAG_W-1:0]  tag_nxt  [QUEUE_DEPTH];
  logic [CW-1:0]              count_r, count_nxt;
  logic [QUEUE_DEPTH-1:0]     ge;

  logic                       item_valid_r, overflow_r, last_r;
  logic [spq_pkg::PRIO_W-1:0] out_prio_r;
  logic [spq_pkg::TAG_W-1:0]  out_tag_r;
  logic [spq_pkg::OCC_W-1:0]  occ_r;

  // Compare every held entry against the incoming priority
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      ge[i] = (count_r > CW'(i)) && (prio_r[i] >= in_priority_req);
    end
  end

  // Shift cells for insert or pop
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      prio_nxt[i] = prio_r[i];
      tag_nxt[i]  = tag_r[i];
    end
    if (cmd.ins) begin
      if (!ge[0]) begin
        prio_nxt[0] = in_priority_req;
        tag_nxt[0]  = in_item_tag;
      end
      for (int i = 1; i < QUEUE_DEPTH; i++) begin
        if (!ge[i]) begin
          if (ge[i-1]) begin
            prio_nxt[i] = in_priority_req;
            tag_nxt[i]  = in_item_tag;
          end else begin
            prio_nxt[i] = prio_r[i-1];
            tag_nxt[i]  = tag_r[i-1];
          end
        end
      end
    end else if (cmd.pop) begin
      for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
        prio_nxt[i] = prio_r[i+1];
        tag_nxt[i]  = tag_r[i+1];
      end
    end
  end

  // Track occupancy
  always_comb begin
    count_nxt = count_r;
    if (cmd.clr) begin
      count_nxt = '0;
    end else if (cmd.ins) begin
      count_nxt = count_r + CW'(1);
    end else if (cmd.pop) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // Store cells hold no reset
  always_ff @(posedge clk) begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      prio_r[i] <= prio_nxt[i];
      tag_r[i]  <= tag_nxt[i];
    end
  end

  // Load the output beat
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_valid_r <= cmd.item_valid;
      overflow_r   <= cmd.overflow;
      last_r       <= cmd.last;
      out_prio_r   <= cmd.item_valid ? prio_r[0] : '0;
      out_tag_r    <= cmd.item_valid ? tag_r[0] : '0;
      occ_r        <= spq_pkg::OCC_W'(count_nxt);
    end
  end

  assign sts.empty  = (count_r == '0);
  assign sts.single = (count_r == CW'(1));
  assign sts.full   = (count_r == CW'(QUEUE_DEPTH));

  assign out_item_valid = item_valid_r;
  assign out_priority   = out_prio_r;
  assign out_tag        = out_tag_r;
  assign out_occupancy  = occ_r;
  assign out_overflow   = overflow_r;
  assign out_last       = last_r;

endmodule

### sv/spq_ctrl.sv
module spq_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [spq_pkg::ACTION_W-1:0] in_action,
  input  logic [spq_pkg::DRAIN_W-1:0]  in_drain_count,
  output logic                         out_valid,
  input  logic                         out_stall,
  output spq_pkg::spq_cmd_t            cmd,
  input  spq_pkg::spq_sts_t            sts
);

  localparam int RW = $clog2(spq_pkg::MAX_RESULTS + 1);
  localparam int XW = (RW > spq_pkg::DRAIN_W) ? RW : spq_pkg::DRAIN_W;

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_DRAIN = 1'b1;

  logic          state_r, state_nxt;
  logic [RW-1:0] rem_r, rem_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          out_free, accept;
  logic [XW-1:0] req_x;
  logic [RW-1:0] rem_init;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r == ST_DRAIN) || !out_free;
  assign accept   = in_valid && !in_stall;

  // Requested drain length, capped at the per-item limit
  always_comb begin
    req_x = XW'(in_drain_count);
    if (in_drain_count == '0 || req_x > XW'(spq_pkg::MAX_RESULTS)) begin
      rem_init = RW'(spq_pkg::MAX_RESULTS);
    end else begin
      rem_init = RW'(in_drain_count);
    end
  end

  // Sequence actions and drain beats
  always_comb begin
    state_nxt = state_r;
    rem_nxt   = rem_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cmd.load = 1'b1;
          cmd.last = 1'b1;
          unique case (in_action)
            spq_pkg::ACT_ENQUEUE: begin
              cmd.ins      = !sts.full;
              cmd.overflow = sts.full;
            end
            spq_pkg::ACT_CLEAR: begin
              cmd.clr = 1'b1;
            end
            spq_pkg::ACT_DEQUEUE: begin
              cmd.pop        = !sts.empty;
              cmd.item_valid = !sts.empty;
            end
            spq_pkg::ACT_DRAIN: begin
              cmd.pop        = !sts.empty;
              cmd.item_valid = !sts.empty;
              cmd.last       = sts.empty || sts.single || (rem_init == RW'(1));
              if (!cmd.last) begin
                rem_nxt   = rem_init - RW'(1);
                state_nxt = ST_DRAIN;
              end
            end
            default: ;
          endcase
        end
      end
      ST_DRAIN: begin
        if (out_free) begin
          cmd.load       = 1'b1;
          cmd.pop        = 1'b1;
          cmd.item_valid = 1'b1;
          cmd.last       = sts.single || (rem_r == RW'(1));
          rem_nxt        = rem_r - RW'(1);
          if (cmd.last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Hold the beat until taken
  always_comb begin
    if (cmd.load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rem_r       <= rem_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

`ifndef SYNTH
  a_ins_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ins |-> !sts.full)
    else $error("insert issued into a full store");

  a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop |-> !sts.empty)
    else $error("pop issued on an empty store");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> out_free)
    else $error("output beat overwritten before it was taken");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_action == spq_pkg::ACT_CLEAR) |=> sts.empty)
    else $error("store not empty after clear");
`endif

endmodule

### sv/sorted_priority_queue_unit.sv
// Sorted priority queue of QUEUE_DEPTH entries (priority and tag), highest
// priority first and first-in first-out among equal priorities. Each input
// beat is one action: enqueue, dequeue, drain or clear. Enqueue, dequeue and
// clear each give a single result beat; a drain gives one result
// beat per removed entry, up to 16, one per cycle, and accepts no new input
// until its last beat is loaded. The rate is set by the single output
// register, which takes one beat per cycle while the consumer does not stall;
// the store is a row of shift cells with one comparator per cell, so inserts
// and pops finish in the cycle they are accepted. Every result reports the
// occupancy after it, masked to five bits. An enqueue into a full queue is
// dropped and flagged with overflow. Stored entries have no reset; only the
// entry count clears.
module sorted_priority_queue_unit #(
  parameter int QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [spq_pkg::ACTION_W-1:0] in_action,
  input  logic [spq_pkg::PRIO_W-1:0]   in_priority_req,
  input  logic [spq_pkg::TAG_W-1:0]    in_item_tag,
  input  logic [spq_pkg::DRAIN_W-1:0]  in_drain_count,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_item_valid,
  output logic [spq_pkg::PRIO_W-1:0]   out_priority,
  output logic [spq_pkg::TAG_W-1:0]    out_tag,
  output logic [spq_pkg::OCC_W-1:0]    out_occupancy,
  output logic                         out_overflow,
  output logic                         out_last
);

  spq_pkg::spq_cmd_t cmd;
  spq_pkg::spq_sts_t sts;

  spq_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_action      (in_action),
    .in_drain_count (in_drain_count),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .cmd            (cmd),
    .sts            (sts)
  );

  spq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_priority_req (in_priority_req),
    .in_item_tag     (in_item_tag),
    .out_item_valid  (out_item_valid),
    .out_priority    (out_priority),
    .out_tag         (out_tag),
    .out_occupancy   (out_occupancy),
    .out_overflow    (out_overflow),
    .out_last        (out_last)
  );

endmodule
